[src/artm_pkg.sv]
package artm_pkg;

  localparam int BUFFER_BYTES = 128;
  localparam int WINDOW_BYTES = 11;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int LIMIT_W   = 16;
  localparam int ELAPSED_W = LIMIT_W + 1;
  localparam int STATUS_W  = 3;

  // byte count only has to reach BUFFER_BYTES-2
  localparam int SEEN_W = $clog2(BUFFER_BYTES - 1);
  localparam logic [SEEN_W-1:0]    OVERRUN_AT  = SEEN_W'(BUFFER_BYTES - 2);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DELIM   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd6;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 3'd7;

  // APB register map
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd62;

  // queue between front and back
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // reply tags; byte k of an entry is the byte k places before the newest one
  localparam int TAG_COUNT = 5;
  localparam int TAG_MAX   = 11;
  localparam logic [BYTE_W-1:0] CR = 8'h0D;
  localparam logic [BYTE_W-1:0] LF = 8'h0A;

  typedef logic [TAG_MAX*BYTE_W-1:0] tag_text_t;

  localparam tag_text_t TAG_TEXT [TAG_COUNT] = '{
    (TAG_MAX*BYTE_W)'({CR, LF, "OK", CR, LF}),
    (TAG_MAX*BYTE_W)'({CR, LF, "ERROR", CR, LF}),
    (TAG_MAX*BYTE_W)'({CR, LF, "FAIL", CR, LF}),
    (TAG_MAX*BYTE_W)'({CR, LF, "SEND OK", CR, LF}),
    (TAG_MAX*BYTE_W)'({" CONNECT", CR, LF})
  };
  localparam int TAG_LEN [TAG_COUNT] = '{6, 9, 8, 11, 10};

  typedef logic [WINDOW_BYTES-1:0][BYTE_W-1:0] window_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_BYTE,
    KIND_TICK
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [BYTE_W-1:0]   rx_byte;
    logic                use_delimiter;
    logic [LIMIT_W-1:0]  timeout_ms;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } front_req_t;

  // one bit per tag that ends at window[0]
  function automatic logic [TAG_COUNT-1:0] tag_hits(window_t w);
    logic [TAG_COUNT-1:0] hit;
    hit = '1;
    for (int t = 0; t < TAG_COUNT; t++) begin
      for (int k = 0; k < TAG_MAX; k++) begin
        if (k < TAG_LEN[t] && k < WINDOW_BYTES) begin
          if (w[k] != TAG_TEXT[t][k*BYTE_W +: BYTE_W]) begin
            hit[t] = 1'b0;
          end
        end
      end
    end
    return hit;
  endfunction

endpackage

[src/at_response_tag_matcher.sv]
// AT reply end detector. Takes one item per clock while in_ready is high: a
// start item arms a search (tag mode or single delimiter mode, plus a
// millisecond limit), byte items are matched against the newest 11 received
// bytes, tick items count milliseconds. At most one status comes out per
// search (tag number 0-4, 5 delimiter, 6 timeout, 7 overrun on the 127th
// byte); items after it are ignored until the next start. An item reaches
// the matcher through a 2-entry queue, and its result is registered in the
// output register. The matcher retires one item per cycle while the output
// register is free or being drained; with a result left waiting, the queue
// absorbs up to two more items before in_ready drops.
// delimiter_char sits at APB address 0 and resets to '>'.
module at_response_tag_matcher (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [artm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [artm_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [artm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [artm_pkg::CMD_W-1:0]           command,
  input  logic [artm_pkg::BYTE_W-1:0]          rx_byte,
  input  logic                                 use_delimiter,
  input  logic [artm_pkg::LIMIT_W-1:0]         timeout_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [artm_pkg::STATUS_W-1:0]        status
);

  logic [artm_pkg::BYTE_W-1:0] delimiter_char;
  artm_pkg::front_req_t        req;
  artm_pkg::q_item_t           head;
  logic                        head_valid;
  logic                        queue_full;
  logic                        pop;
  logic                        reg_sel;

  // delimiter_char is the only register, at byte address 0
  assign reg_sel = (paddr == '0);
  assign pready  = 1'b1;
  assign prdata  = {{(artm_pkg::APB_DATA_W - artm_pkg::BYTE_W){1'b0}}, delimiter_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= artm_pkg::DELIM_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      delimiter_char <= pwdata[artm_pkg::BYTE_W-1:0];
    end
  end

  artm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .rx_byte       (rx_byte),
    .use_delimiter (use_delimiter),
    .timeout_ms    (timeout_ms),
    .queue_full    (queue_full),
    .req           (req)
  );

  artm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (queue_full)
  );

  artm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .delimiter_char (delimiter_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status)
  );

endmodule

[src/artm_front.sv]
module artm_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [artm_pkg::CMD_W-1:0]           command,
  input  logic [artm_pkg::BYTE_W-1:0]          rx_byte,
  input  logic                                 use_delimiter,
  input  logic [artm_pkg::LIMIT_W-1:0]         timeout_ms,
  input  logic                                 queue_full,
  output artm_pkg::front_req_t                 req
);

  logic known;

  assign in_ready = !queue_full;

  // unused command codes are accepted and dropped here
  always_comb begin
    req.item.rx_byte       = rx_byte;
    req.item.use_delimiter = use_delimiter;
    req.item.timeout_ms    = timeout_ms;
    req.item.kind          = artm_pkg::KIND_START;
    known                  = 1'b1;
    unique case (command)
      artm_pkg::CMD_START: req.item.kind = artm_pkg::KIND_START;
      artm_pkg::CMD_BYTE:  req.item.kind = artm_pkg::KIND_BYTE;
      artm_pkg::CMD_TICK:  req.item.kind = artm_pkg::KIND_TICK;
      default:             known         = 1'b0;
    endcase
    req.push = in_valid && in_ready && known;
  end

endmodule

[src/artm_queue.sv]
module artm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  artm_pkg::front_req_t req,
  input  logic                 pop,
  output logic                 head_valid,
  output artm_pkg::q_item_t    head,
  output logic                 full
);

  artm_pkg::q_item_t                entries [artm_pkg::QUEUE_DEPTH];
  logic [artm_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [artm_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [artm_pkg::QCOUNT_W-1:0]    count;
  logic                             do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == artm_pkg::QCOUNT_W'(artm_pkg::QUEUE_DEPTH));
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (req.push) begin
      entries[wr_ptr] <= req.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (req.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!req.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !req.push)
    else $error("queue written while full");

endmodule

[src/artm_back.sv]
module artm_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  artm_pkg::q_item_t                    head,
  output logic                                 pop,
  input  logic [artm_pkg::BYTE_W-1:0]          delimiter_char,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [artm_pkg::STATUS_W-1:0]        status
);

  artm_pkg::window_t                   window, window_next, shifted;
  logic [artm_pkg::SEEN_W-1:0]         bytes_seen, bytes_seen_next;
  logic [artm_pkg::ELAPSED_W-1:0]      elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic [artm_pkg::LIMIT_W-1:0]        time_limit, time_limit_next;
  logic                                delimiter_mode, delimiter_mode_next;
  logic                                searching, searching_next;
  logic [artm_pkg::TAG_COUNT-1:0]      hits;
  logic                                has_result;
  logic [artm_pkg::STATUS_W-1:0]       result_code;

  assign pop     = head_valid && (!out_valid || out_ready);
  assign shifted = {window[artm_pkg::WINDOW_BYTES-2:0], head.rx_byte};
  assign hits    = artm_pkg::tag_hits(shifted);
  assign elapsed_inc = (elapsed_ms == artm_pkg::ELAPSED_MAX) ? elapsed_ms
                                                             : elapsed_ms + 1'b1;

  always_comb begin
    window_next         = window;
    bytes_seen_next     = bytes_seen;
    elapsed_ms_next     = elapsed_ms;
    time_limit_next     = time_limit;
    delimiter_mode_next = delimiter_mode;
    searching_next      = searching;
    has_result          = 1'b0;
    result_code         = artm_pkg::ST_OVERRUN;
    if (pop) begin
      case (head.kind)
        artm_pkg::KIND_START: begin
          window_next         = '0;
          bytes_seen_next     = '0;
          elapsed_ms_next     = '0;
          time_limit_next     = head.timeout_ms;
          delimiter_mode_next = head.use_delimiter;
          searching_next      = 1'b1;
        end
        artm_pkg::KIND_BYTE: begin
          if (searching) begin
            if (bytes_seen >= artm_pkg::OVERRUN_AT) begin
              has_result     = 1'b1;
              result_code    = artm_pkg::ST_OVERRUN;
              searching_next = 1'b0;
            end else begin
              bytes_seen_next = bytes_seen + 1'b1;
              window_next     = shifted;
              if (delimiter_mode) begin
                if (head.rx_byte == delimiter_char) begin
                  has_result  = 1'b1;
                  result_code = artm_pkg::ST_DELIM;
                end
              end else begin
                // walk down so the lowest tag number wins
                for (int t = artm_pkg::TAG_COUNT - 1; t >= 0; t--) begin
                  if (hits[t]) begin
                    has_result  = 1'b1;
                    result_code = artm_pkg::STATUS_W'(t);
                  end
                end
              end
              if (has_result) begin
                searching_next = 1'b0;
              end
            end
          end
        end
        artm_pkg::KIND_TICK: begin
          if (searching) begin
            elapsed_ms_next = elapsed_inc;
            if (elapsed_inc > {1'b0, time_limit}) begin
              has_result     = 1'b1;
              result_code    = artm_pkg::ST_TIMEOUT;
              searching_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      bytes_seen     <= '0;
      elapsed_ms     <= '0;
      time_limit     <= '0;
      delimiter_mode <= 1'b0;
      searching      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      window         <= window_next;
      bytes_seen     <= bytes_seen_next;
      elapsed_ms     <= elapsed_ms_next;
      time_limit     <= time_limit_next;
      delimiter_mode <= delimiter_mode_next;
      searching      <= searching_next;
      if (pop) begin
        out_valid <= has_result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      status <= result_code;
    end
  end

  a_result_ends_search: assert property (@(posedge clk) disable iff (rst)
    pop && has_result |=> !searching && out_valid)
    else $error("search still armed after a result");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= artm_pkg::OVERRUN_AT)
    else $error("byte count past overrun point");

  a_elapsed_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(pop && (head.kind == artm_pkg::KIND_TICK || head.kind == artm_pkg::KIND_START))
    |=> $stable(elapsed_ms))
    else $error("elapsed time moved without a tick");

endmodule
